### sv/page_diff_run_length_encoder_assert.svh
// Assertion macros used by the page difference encoder top level.
`ifndef PAGE_DIFF_RUN_LENGTH_ENCODER_ASSERT_SVH
`define PAGE_DIFF_RUN_LENGTH_ENCODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PDRLE_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("pdrle same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PDRLE_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("pdrle next-cycle check failed");

`endif

### sv/pdrle_pkg.sv
// Types and constants of the page difference run-length encoder.
package pdrle_pkg;

    localparam int LEN_BITS = 16;
    localparam logic [15:0] RUN_MAX = (LEN_BITS >= 16) ? 16'hFFFF
                                                       : 16'((1 << LEN_BITS) - 1);
    localparam logic [16:0] SAT17 = 17'h1FFFF;

    // Results one item can cause at most.
    localparam int RES_MAX   = 4;
    localparam int RES_CNT_W = $clog2(RES_MAX + 1);

    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    localparam int ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_COMPARE_TO_ZERO = 2'd0,
        REG_PAGE_BYTES      = 2'd1,
        REG_DIFF_BUDGET     = 2'd2,
        REG_MAX_ENTRIES     = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        KIND_DIFF_RUN       = 3'd0,
        KIND_EQUAL_RUN      = 3'd1,
        KIND_DONE_OK        = 3'd2,
        KIND_DONE_NO_CHANGE = 3'd3,
        KIND_BUDGET_FAIL    = 3'd4,
        KIND_ENTRY_FAIL     = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_DIFF  = 2'd1,
        PH_EQUAL = 2'd2
    } phase_t;

    typedef struct packed {
        logic        compare_to_zero;
        logic [15:0] page_bytes;
        logic [15:0] diff_budget;
        logic [15:0] max_entries;
    } cfg_t;

    // A classified byte: whether it differs and whether it closes the page.
    typedef struct packed {
        logic diff;
        logic page_end;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] run_length;
        logic        last;
    } result_t;

endpackage

### sv/page_diff_run_length_encoder.sv
// Top level of the page difference run-length encoder with its register port.
// Path: front stage register, item queue, then result queue. Throughput: one byte per cycle
// while the item queue has room; the back stage retires one item per cycle while the result
// queue has room for four results, so popping sets the rate on result-heavy pages.
// Reset: rst_n clears all queues, page state and registers to their defaults at once.
`include "page_diff_run_length_encoder_assert.svh"

module page_diff_run_length_encoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pdrle_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    old_byte,
    input  logic [7:0]                    new_byte,
    input  logic                          forced,
    input  logic                          page_end,
    output logic                          empty,
    input  logic                          pop,
    output logic [2:0]                    kind,
    output logic [15:0]                   run_length,
    output logic                          last
);
    import pdrle_pkg::*;

    cfg_t                 cfg_reg;
    reg_index_t           reg_sel;
    logic                 cfg_write;
    logic                 q_push;
    item_t                q_data;
    logic                 q_full;
    logic                 q_pop;
    item_t                q_head;
    logic                 q_empty;
    logic                 out_room;
    logic [RES_CNT_W-1:0] wr_count;
    result_t              wr_data [RES_MAX];
    result_t              out_head;

    assign pready    = 1'b1;
    assign reg_sel   = reg_index_t'(paddr[ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (reg_sel)
            REG_COMPARE_TO_ZERO: prdata = {31'd0, cfg_reg.compare_to_zero};
            REG_PAGE_BYTES:      prdata = {16'd0, cfg_reg.page_bytes};
            REG_DIFF_BUDGET:     prdata = {16'd0, cfg_reg.diff_budget};
            REG_MAX_ENTRIES:     prdata = {16'd0, cfg_reg.max_entries};
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.compare_to_zero <= 1'b0;
            cfg_reg.page_bytes      <= 16'd4096;
            cfg_reg.diff_budget     <= 16'd0;
            cfg_reg.max_entries     <= 16'hFFFF;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_COMPARE_TO_ZERO: cfg_reg.compare_to_zero <= pwdata[0];
                REG_PAGE_BYTES:      cfg_reg.page_bytes      <= pwdata[15:0];
                REG_DIFF_BUDGET:     cfg_reg.diff_budget     <= pwdata[15:0];
                REG_MAX_ENTRIES:     cfg_reg.max_entries     <= pwdata[15:0];
                default:             cfg_reg.max_entries     <= cfg_reg.max_entries;
            endcase
        end
    end

    pdrle_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .compare_to_zero (cfg_reg.compare_to_zero),
        .push            (push),
        .full            (full),
        .old_byte        (old_byte),
        .new_byte        (new_byte),
        .forced          (forced),
        .page_end        (page_end),
        .q_push          (q_push),
        .q_data          (q_data),
        .q_full          (q_full)
    );

    pdrle_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .q_full    (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .q_empty   (q_empty)
    );

    pdrle_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .head     (q_head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .out_room (out_room),
        .wr_count (wr_count),
        .wr_data  (wr_data)
    );

    pdrle_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_count (wr_count),
        .wr_data  (wr_data),
        .out_room (out_room),
        .pop      (pop),
        .empty    (empty),
        .head     (out_head)
    );

    assign kind       = 3'(out_head.kind);
    assign run_length = out_head.run_length;
    assign last       = out_head.last;

    // An accepted item is held in the front stage on the next cycle.
    `PDRLE_ASSERT_NEXT(a_front_holds_item, clk, rst_n, push && !full, u_front.valid_reg)
    // The back stage only retires an item that is in the queue.
    `PDRLE_ASSERT_SAME(a_pop_nonempty, clk, rst_n, q_pop, !q_empty)
    // Results are only written when the result queue can hold a full burst.
    `PDRLE_ASSERT_SAME(a_write_room, clk, rst_n, wr_count != '0, out_room)

endmodule

### sv/pdrle_front.sv
// Front stage: accepts byte items and classifies each as differing or equal.
module pdrle_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            compare_to_zero,
    input  logic            push,
    output logic            full,
    input  logic [7:0]      old_byte,
    input  logic [7:0]      new_byte,
    input  logic            forced,
    input  logic            page_end,
    output logic            q_push,
    output pdrle_pkg::item_t q_data,
    input  logic            q_full
);
    import pdrle_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;
    logic  diff;

    assign full   = valid_reg && q_full;
    assign accept = push && !full;
    assign diff   = forced || (compare_to_zero ? (old_byte != 8'd0) : (old_byte != new_byte));

    assign q_push = valid_reg && !q_full;
    assign q_data = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (q_push)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= '{diff: diff, page_end: page_end};
        end
    end

endmodule

### sv/pdrle_queue.sv
// Short queue of classified items between the front and back stages.
module pdrle_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pdrle_pkg::item_t push_data,
    output logic             q_full,
    input  logic             pop,
    output pdrle_pkg::item_t head,
    output logic             q_empty
);
    import pdrle_pkg::*;

    item_t              mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wptr_reg;
    logic [Q_PTR_W-1:0] rptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;

    assign q_full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign q_empty = (count_reg == '0);
    assign head    = mem_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

endmodule

### sv/pdrle_back.sv
// Back stage: run, budget and entry tracking; turns each item into its results.
module pdrle_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  pdrle_pkg::cfg_t                  cfg,
    input  pdrle_pkg::item_t                 head,
    input  logic                             q_empty,
    output logic                             q_pop,
    input  logic                             out_room,
    output logic [pdrle_pkg::RES_CNT_W-1:0]  wr_count,
    output pdrle_pkg::result_t               wr_data [pdrle_pkg::RES_MAX]
);
    import pdrle_pkg::*;

    phase_t      phase_reg,   phase_next;
    logic [15:0] run_reg,     run_next;
    logic [16:0] budget_reg,  budget_next;
    logic [16:0] entries_reg, entries_next;
    logic        any_diff_reg, any_diff_next;
    logic        failed_reg,  failed_next;
    logic [16:0] limit;
    logic [17:0] page_x3;
    logic        take;

    // Default budget is three quarters of the page.
    assign page_x3 = {2'b00, cfg.page_bytes} + {1'b0, cfg.page_bytes, 1'b0};
    assign limit   = (cfg.diff_budget != 16'd0) ? {1'b0, cfg.diff_budget}
                                                : {1'b0, page_x3[17:2]};

    assign take  = !q_empty && out_room;
    assign q_pop = take;

    always_comb
    begin
        logic [17:0]          sum;
        logic                 fail;
        kind_t                fail_kind;
        logic [RES_CNT_W-1:0] n;

        phase_next    = phase_reg;
        run_next      = run_reg;
        budget_next   = budget_reg;
        entries_next  = entries_reg;
        any_diff_next = any_diff_reg;
        failed_next   = failed_reg;
        fail          = 1'b0;
        fail_kind     = KIND_ENTRY_FAIL;
        sum           = '0;
        n             = '0;
        for (int k = 0; k < RES_MAX; k++)
        begin
            wr_data[k] = '{KIND_DIFF_RUN, 16'd0, 1'b0};
        end

        if (failed_reg)
        begin
            // The rest of a failed page is dropped.
            if (head.page_end)
            begin
                failed_next = 1'b0;
                phase_next  = PH_START;
            end
        end
        else
        begin
            if (phase_reg == PH_START)
            begin
                budget_next   = '0;
                entries_next  = '0;
                any_diff_next = 1'b0;
                run_next      = '0;
                if (cfg.compare_to_zero)
                begin
                    wr_data[0]   = '{KIND_DIFF_RUN, 16'd0, 1'b0};
                    wr_data[1]   = '{KIND_EQUAL_RUN, 16'd0, 1'b0};
                    n            = RES_CNT_W'(2);
                    entries_next = 17'd2;
                end
                phase_next = PH_DIFF;
                if (entries_next >= {1'b0, cfg.max_entries})
                begin
                    fail      = 1'b1;
                    fail_kind = KIND_ENTRY_FAIL;
                end
            end

            if (!fail)
            begin
                if (phase_next == PH_DIFF)
                begin
                    if (head.diff)
                    begin
                        if (run_next < RUN_MAX)
                        begin
                            run_next = run_next + 16'd1;
                        end
                        any_diff_next = 1'b1;
                    end
                    else
                    begin
                        sum = {1'b0, budget_next} + {2'b00, run_next} + 18'd2;
                        budget_next = (sum > {1'b0, SAT17}) ? SAT17 : sum[16:0];
                        if (budget_next > limit)
                        begin
                            fail      = 1'b1;
                            fail_kind = KIND_BUDGET_FAIL;
                        end
                        else
                        begin
                            wr_data[n[1:0]] = '{KIND_DIFF_RUN, run_next, 1'b0};
                            n = n + 1'b1;
                            if (entries_next != SAT17)
                            begin
                                entries_next = entries_next + 17'd1;
                            end
                            phase_next = PH_EQUAL;
                            run_next   = 16'd1;
                        end
                    end
                end
                else
                begin
                    if (head.diff)
                    begin
                        wr_data[n[1:0]] = '{KIND_EQUAL_RUN, run_next, 1'b0};
                        n = n + 1'b1;
                        if (entries_next != SAT17)
                        begin
                            entries_next = entries_next + 17'd1;
                        end
                        phase_next    = PH_DIFF;
                        run_next      = 16'd1;
                        any_diff_next = 1'b1;
                        if (entries_next >= {1'b0, cfg.max_entries})
                        begin
                            fail      = 1'b1;
                            fail_kind = KIND_ENTRY_FAIL;
                        end
                    end
                    else if (run_next < RUN_MAX)
                    begin
                        run_next = run_next + 16'd1;
                    end
                end
            end

            if (!fail && head.page_end)
            begin
                // Close a differing run; a trailing equal run is never sent.
                if (phase_next == PH_DIFF)
                begin
                    sum = {1'b0, budget_next} + {2'b00, run_next} + 18'd2;
                    budget_next = (sum > {1'b0, SAT17}) ? SAT17 : sum[16:0];
                    if (budget_next > limit)
                    begin
                        fail      = 1'b1;
                        fail_kind = KIND_BUDGET_FAIL;
                    end
                    else if (run_next != 16'd0)
                    begin
                        wr_data[n[1:0]] = '{KIND_DIFF_RUN, run_next, 1'b0};
                        n = n + 1'b1;
                        if (entries_next != SAT17)
                        begin
                            entries_next = entries_next + 17'd1;
                        end
                    end
                end
                if (!fail)
                begin
                    wr_data[n[1:0]] = '{(cfg.compare_to_zero || any_diff_next) ?
                                        KIND_DONE_OK : KIND_DONE_NO_CHANGE, 16'd0, 1'b1};
                    n = n + 1'b1;
                    phase_next = PH_START;
                    run_next   = '0;
                end
            end

            if (fail)
            begin
                wr_data[n[1:0]] = '{fail_kind, 16'd0, 1'b1};
                n = n + 1'b1;
                run_next    = '0;
                phase_next  = PH_START;
                failed_next = !head.page_end;
            end
        end

        wr_count = take ? n : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_START;
            run_reg      <= '0;
            budget_reg   <= '0;
            entries_reg  <= '0;
            any_diff_reg <= 1'b0;
            failed_reg   <= 1'b0;
        end
        else if (take)
        begin
            phase_reg    <= phase_next;
            run_reg      <= run_next;
            budget_reg   <= budget_next;
            entries_reg  <= entries_next;
            any_diff_reg <= any_diff_next;
            failed_reg   <= failed_next;
        end
    end

endmodule

### sv/pdrle_out_fifo.sv
// Result queue: takes up to four results a cycle, hands out one at a time.
module pdrle_out_fifo (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [pdrle_pkg::RES_CNT_W-1:0] wr_count,
    input  pdrle_pkg::result_t              wr_data [pdrle_pkg::RES_MAX],
    output logic                            out_room,
    input  logic                            pop,
    output logic                            empty,
    output pdrle_pkg::result_t              head
);
    import pdrle_pkg::*;

    result_t              mem_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wptr_reg;
    logic [OUT_PTR_W-1:0] rptr_reg;
    logic [OUT_CNT_W-1:0] count_reg;
    logic [OUT_CNT_W-1:0] count_next;
    logic                 do_pop;

    assign empty    = (count_reg == '0);
    assign do_pop   = pop && !empty;
    assign head     = mem_reg[rptr_reg];
    // Room for the largest burst one item can cause.
    assign out_room = (count_reg <= OUT_CNT_W'(OUT_DEPTH - RES_MAX));

    assign count_next = count_reg + OUT_CNT_W'(wr_count) - OUT_CNT_W'(do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_reg + OUT_PTR_W'(wr_count);
            rptr_reg  <= rptr_reg + OUT_PTR_W'(do_pop);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < RES_MAX; k++)
        begin
            if (RES_CNT_W'(k) < wr_count)
            begin
                mem_reg[wptr_reg + OUT_PTR_W'(k)] <= wr_data[k];
            end
        end
    end

endmodule

### tb/sv/tb_page_diff_run_length_encoder.sv
// Self-checking testbench for the page difference run-length encoder.
`timescale 1ns / 1ps

module tb_page_diff_run_length_encoder;
    import pdrle_pkg::*;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  old_byte = 8'd0;
    logic [7:0]  new_byte = 8'd0;
    logic        forced = 1'b0;
    logic        page_end = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  kind;
    logic [15:0] run_length;
    logic        last;

    page_diff_run_length_encoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .push       (push),
        .full       (full),
        .old_byte   (old_byte),
        .new_byte   (new_byte),
        .forced     (forced),
        .page_end   (page_end),
        .empty      (empty),
        .pop        (pop),
        .kind       (kind),
        .run_length (run_length),
        .last       (last)
    );

    // Register copies held by the predictor.
    logic        cfg_zero = 1'b0;
    logic [15:0] cfg_page_bytes = 16'd4096;
    logic [15:0] cfg_diff_budget = 16'd0;
    logic [15:0] cfg_max_entries = 16'hFFFF;

    // Page state of the predictor.
    phase_t      enc_phase = PH_START;
    logic [15:0] enc_run = 16'd0;
    logic [16:0] enc_budget = 17'd0;
    logic [16:0] enc_entries = 17'd0;
    logic        enc_any_diff = 1'b0;
    logic        enc_failed = 1'b0;

    result_t     expected_runs[$];

    bit          idle_on = 1'b1;
    int          hold_left = 0;
    int          mismatches = 0;
    int          results_checked = 0;
    int          bytes_sent = 0;
    int          pages_sent = 0;
    int          full_stalls = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $error("run did not finish in time");
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void queue_result(input kind_t k, input logic [15:0] len, input logic l);
        result_t r;
        r = '{kind: k, run_length: len, last: l};
        expected_runs.insert(expected_runs.size(), r);
    endfunction

    function automatic void count_run_entry();
        if (enc_entries < SAT17)
            enc_entries++;
    endfunction

    // Charges the differing run that is closing now; true while the page stays in budget.
    function automatic bit within_budget_after_run();
        int unsigned total;
        int unsigned cap;
        total = int'(enc_budget) + int'(enc_run) + 2;
        enc_budget = (total > SAT17) ? SAT17 : total[16:0];
        cap = (cfg_diff_budget != 16'd0) ? int'(cfg_diff_budget)
                                         : (int'(cfg_page_bytes) * 3) >> 2;
        return int'(enc_budget) <= cap;
    endfunction

    function automatic void encode_byte(input logic [7:0] ob, input logic [7:0] nb,
                                        input logic frc, input logic endp);
        logic  d;
        logic  fail_now;
        kind_t fail_kind;
        d = frc || (cfg_zero ? (ob != 8'd0) : (ob != nb));
        fail_now = 1'b0;
        fail_kind = KIND_ENTRY_FAIL;
        if (enc_failed)
        begin
            // The rest of a failed page is dropped up to its last byte.
            if (endp)
            begin
                enc_failed = 1'b0;
                enc_phase = PH_START;
            end
            return;
        end
        if (enc_phase == PH_START)
        begin
            enc_budget = 17'd0;
            enc_entries = 17'd0;
            enc_any_diff = 1'b0;
            enc_run = 16'd0;
            if (cfg_zero)
            begin
                queue_result(KIND_DIFF_RUN, 16'd0, 1'b0);
                queue_result(KIND_EQUAL_RUN, 16'd0, 1'b0);
                enc_entries = 17'd2;
            end
            enc_phase = PH_DIFF;
            if (enc_entries >= cfg_max_entries)
                fail_now = 1'b1;
        end
        if (!fail_now)
        begin
            if (enc_phase == PH_DIFF)
            begin
                if (d)
                begin
                    if (enc_run < RUN_MAX)
                        enc_run++;
                    enc_any_diff = 1'b1;
                end
                else if (!within_budget_after_run())
                begin
                    fail_now = 1'b1;
                    fail_kind = KIND_BUDGET_FAIL;
                end
                else
                begin
                    queue_result(KIND_DIFF_RUN, enc_run, 1'b0);
                    count_run_entry();
                    enc_phase = PH_EQUAL;
                    enc_run = 16'd1;
                end
            end
            else if (d)
            begin
                queue_result(KIND_EQUAL_RUN, enc_run, 1'b0);
                count_run_entry();
                enc_phase = PH_DIFF;
                enc_run = 16'd1;
                enc_any_diff = 1'b1;
                if (enc_entries >= cfg_max_entries)
                    fail_now = 1'b1;
            end
            else if (enc_run < RUN_MAX)
            begin
                enc_run++;
            end
        end
        if (!fail_now && endp)
        begin
            if (enc_phase == PH_DIFF)
            begin
                if (!within_budget_after_run())
                begin
                    fail_now = 1'b1;
                    fail_kind = KIND_BUDGET_FAIL;
                end
                else if (enc_run != 16'd0)
                begin
                    queue_result(KIND_DIFF_RUN, enc_run, 1'b0);
                    count_run_entry();
                end
            end
            if (!fail_now)
            begin
                queue_result((cfg_zero || enc_any_diff) ? KIND_DONE_OK : KIND_DONE_NO_CHANGE,
                             16'd0, 1'b1);
                enc_phase = PH_START;
                enc_run = 16'd0;
            end
        end
        if (fail_now)
        begin
            queue_result(fail_kind, 16'd0, 1'b1);
            enc_run = 16'd0;
            enc_phase = PH_START;
            enc_failed = !endp;
        end
    endfunction

    // Writes one register, reads it back, and updates the predictor's copy.
    task automatic write_register(input reg_index_t idx, input logic [31:0] value);
        logic [31:0] mask;
        mask = (idx == REG_COMPARE_TO_ZERO) ? 32'h1 : 32'hFFFF;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_COMPARE_TO_ZERO: cfg_zero = value[0];
            REG_PAGE_BYTES:      cfg_page_bytes = value[15:0];
            REG_DIFF_BUDGET:     cfg_diff_budget = value[15:0];
            REG_MAX_ENTRIES:     cfg_max_entries = value[15:0];
            default:             ;
        endcase
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== (value & mask))
        begin
            $error("prdata: expected %0h, got %0h", value & mask, prdata);
            mismatches++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Offers one byte from a falling edge and returns at the falling edge after it is taken.
    task automatic send_byte(input logic [7:0] ob, input logic [7:0] nb,
                             input logic frc, input logic endp);
        while (idle_on && $urandom_range(99) < 38)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        old_byte <= ob;
        new_byte <= nb;
        forced <= frc;
        page_end <= endp;
        @(posedge clk);
        while (full)
        begin
            full_stalls++;
            @(posedge clk);
        end
        encode_byte(ob, nb, frc, endp);
        bytes_sent++;
        if (endp)
            pages_sent++;
        @(negedge clk);
    endtask

    task automatic stop_sending();
        push <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        int spins;
        spins = 0;
        while (expected_runs.size() != 0 && spins < 50000)
        begin
            @(posedge clk);
            spins++;
        end
        if (expected_runs.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_runs.size());
            mismatches++;
            expected_runs.delete();
        end
        // Items that cause no result may still be in flight.
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    // A page built from runs of differing and equal bytes; a noisy page also ends pages early.
    task automatic send_random_page(input bit noisy);
        int         len;
        int         run_left;
        bit         diff_run;
        logic [7:0] ob;
        logic [7:0] nb;
        len = ($urandom_range(7) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 1);
        diff_run = 1'($urandom_range(1));
        run_left = $urandom_range(5, 1);
        for (int i = 0; i < len; i++)
        begin
            if (run_left == 0)
            begin
                diff_run = !diff_run;
                run_left = $urandom_range(6, 1);
            end
            run_left--;
            ob = 8'($urandom_range(255));
            nb = 8'($urandom_range(255));
            if (diff_run)
            begin
                if (cfg_zero)
                    ob = 8'($urandom_range(255, 1));
                else if (nb == ob)
                    nb = ~ob;
            end
            else if (cfg_zero)
                ob = 8'd0;
            else
                nb = ob;
            send_byte(ob, nb, $urandom_range(15) == 0,
                      (i == len - 1) || (noisy && $urandom_range(5) == 0));
        end
    endtask

    task automatic test_compare_mode();
        // Leading equal bytes open with an empty differing run.
        send_byte(8'h00, 8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 8'hFF, 1'b0, 1'b0);
        send_byte(8'hFF, 8'h00, 1'b0, 1'b0);
        send_byte(8'h00, 8'hFF, 1'b0, 1'b0);
        send_byte(8'hAA, 8'hAA, 1'b0, 1'b1);
        send_byte(8'h12, 8'h12, 1'b0, 1'b0);
        send_byte(8'h34, 8'h34, 1'b0, 1'b1);
        // Forced bytes differ even when the pages agree.
        send_byte(8'h55, 8'h55, 1'b1, 1'b0);
        send_byte(8'h00, 8'h00, 1'b1, 1'b1);
        send_byte(8'hFF, 8'h00, 1'b0, 1'b1);
        stop_sending();
        wait_for_results();
    endtask

    task automatic test_zero_mode();
        write_register(REG_COMPARE_TO_ZERO, 32'd1);
        send_byte(8'h00, 8'hFF, 1'b0, 1'b0);
        send_byte(8'hFF, 8'h00, 1'b0, 1'b0);
        send_byte(8'h00, 8'h00, 1'b0, 1'b1);
        send_byte(8'h00, 8'h00, 1'b0, 1'b1);
        stop_sending();
        wait_for_results();
        // The two prefix entries already exceed a limit of one.
        write_register(REG_MAX_ENTRIES, 32'd1);
        send_byte(8'h01, 8'h00, 1'b0, 1'b0);
        send_byte(8'h00, 8'h00, 1'b0, 1'b1);
        send_byte(8'h00, 8'h00, 1'b0, 1'b1);
        stop_sending();
        wait_for_results();
    endtask

    task automatic test_limits();
        write_register(REG_COMPARE_TO_ZERO, 32'd0);
        write_register(REG_MAX_ENTRIES, 32'hFFFF);
        write_register(REG_DIFF_BUDGET, 32'd3);
        send_byte(8'hFF, 8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 8'h00, 1'b0, 1'b0);
        send_byte(8'h00, 8'h00, 1'b0, 1'b1);
        stop_sending();
        wait_for_results();
        write_register(REG_MAX_ENTRIES, 32'd2);
        send_byte(8'h00, 8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 8'h00, 1'b0, 1'b0);
        send_byte(8'h00, 8'h00, 1'b0, 1'b1);
        stop_sending();
        wait_for_results();
        // A one-byte page gives a default budget of zero.
        write_register(REG_MAX_ENTRIES, 32'hFFFF);
        write_register(REG_DIFF_BUDGET, 32'd0);
        write_register(REG_PAGE_BYTES, 32'd1);
        send_byte(8'h00, 8'h00, 1'b0, 1'b1);
        stop_sending();
        wait_for_results();
    endtask

    task automatic test_full_queue();
        // A large budget keeps every page alive so each byte pair yields results.
        write_register(REG_PAGE_BYTES, 32'hFFFF);
        write_register(REG_DIFF_BUDGET, 32'hFFFF);
        idle_on = 1'b0;
        hold_left = 200;
        for (int i = 0; i < 64; i++)
            send_byte(i[0] ? 8'h00 : 8'hC3, 8'h00, 1'b0, (i % 16) == 15);
        stop_sending();
        wait_for_results();
        idle_on = 1'b1;
    endtask

    task automatic test_pause_mid_page();
        for (int i = 0; i < 6; i++)
            send_byte(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0, 1'b0);
        stop_sending();
        wait_for_results();
        for (int i = 0; i < 6; i++)
            send_byte(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0, i == 5);
        stop_sending();
        wait_for_results();
    endtask

    task automatic test_random_pages();
        int target;
        for (int ph = 0; ph < 4; ph++)
        begin
            write_register(REG_COMPARE_TO_ZERO, $urandom_range(1));
            case ($urandom_range(3))
                0:       write_register(REG_PAGE_BYTES, 32'd1);
                1:       write_register(REG_PAGE_BYTES, 32'hFFFF);
                2:       write_register(REG_PAGE_BYTES, $urandom_range(64, 2));
                default: write_register(REG_PAGE_BYTES, $urandom_range(65535, 1));
            endcase
            case ($urandom_range(3))
                0:       write_register(REG_DIFF_BUDGET, 32'd0);
                1:       write_register(REG_DIFF_BUDGET, 32'hFFFF);
                2:       write_register(REG_DIFF_BUDGET, $urandom_range(40, 1));
                default: write_register(REG_DIFF_BUDGET, $urandom_range(400, 41));
            endcase
            case ($urandom_range(3))
                0:       write_register(REG_MAX_ENTRIES, 32'd1);
                1:       write_register(REG_MAX_ENTRIES, 32'hFFFF);
                2:       write_register(REG_MAX_ENTRIES, $urandom_range(12, 2));
                default: write_register(REG_MAX_ENTRIES, $urandom_range(200, 13));
            endcase
            // One phase runs with neither side idling.
            idle_on = (ph != 2);
            target = bytes_sent + 40;
            while (bytes_sent < target)
                send_random_page($urandom_range(4) == 0);
            stop_sending();
            wait_for_results();
        end
        idle_on = 1'b1;
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
        begin
            pop <= !(idle_on && $urandom_range(99) < 38);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_runs.size() == 0)
            begin
                $error("kind %0d length %0d arrived with nothing expected", kind, run_length);
                mismatches++;
            end
            else
            begin
                want = expected_runs.pop_front();
                results_checked++;
                if (kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, kind);
                    mismatches++;
                end
                if (run_length !== want.run_length)
                begin
                    $error("run_length: expected %0d, got %0d", want.run_length, run_length);
                    mismatches++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_compare_mode();
        test_zero_mode();
        test_limits();
        test_full_queue();
        test_pause_mid_page();
        test_random_pages();
        $display("Checked %0d results from %0d bytes in %0d pages; input held off %0d cycles.",
                 results_checked, bytes_sent, pages_sent, full_stalls);
        $display("Both compare modes, forced bytes, both failure kinds and a stalled reader ran.");
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
